// ===== src/stt_pkg.sv =====
`timescale 1ns / 1ps
package stt_pkg;

  localparam int unsigned DefTableEntries = 16;

  // Input modes.
  localparam logic [1:0] MODE_ADV   = 2'd0;
  localparam logic [1:0] MODE_SEND  = 2'd1;
  localparam logic [1:0] MODE_RELAY = 2'd2;

  // Result status codes.
  localparam logic [3:0] STAT_STALE     = 4'd0;
  localparam logic [3:0] STAT_UPDATED   = 4'd1;
  localparam logic [3:0] STAT_INSERTED  = 4'd2;
  localparam logic [3:0] STAT_FULL      = 4'd3;
  localparam logic [3:0] STAT_ROUTED    = 4'd4;
  localparam logic [3:0] STAT_NO_ROUTE  = 4'd5;
  localparam logic [3:0] STAT_NOT_FOR_ME = 4'd6;
  localparam logic [3:0] STAT_DELIVERED = 4'd7;
  localparam logic [3:0] STAT_FORWARDED = 4'd8;
  localparam logic [3:0] STAT_TTL_DEAD  = 4'd9;

  // Configuration register indexes.
  localparam logic [7:0] CFG_OWN_ID   = 8'd0;
  localparam logic [7:0] CFG_EXPIRY   = 8'd1;
  localparam logic [7:0] CFG_MAX_HOPS = 8'd2;
  localparam logic [7:0] CFG_MSG_TTL  = 8'd3;

  localparam logic [4:0] CountMax = 5'd31;

  typedef struct packed {
    logic [15:0] sink;
    logic [15:0] nhop;
    logic [7:0]  hops;
    logic [31:0] created;
  } entry_t;

  typedef struct packed {
    logic match;
    logic expired;
  } cmp_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_WRITE,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

// ===== src/stt_ram.sv =====
`timescale 1ns / 1ps
module stt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/stt_cmp.sv =====
`timescale 1ns / 1ps
module stt_cmp
  import stt_pkg::*;
(
  input  entry_t      entry,
  input  logic [15:0] key_sink,
  input  logic [31:0] now,
  input  logic [31:0] expiry,
  output cmp_res_t    res
);

  logic [31:0] age;

  // Age wraps modulo 2^32, as the tick counter does.
  assign age         = now - entry.created;
  assign res.match   = (entry.sink == key_sink);
  assign res.expired = (age > expiry);

endmodule

// ===== src/sink_tree_routing_table_top.sv =====
`timescale 1ns / 1ps
// Sink tree routing table: one entry per sink with next hop, hop count and
// creation time. An item on the in_ channel carries a mode (advertisement,
// originate send or relay) and its fields; each item yields exactly one
// result item on the out_ channel. Both channels use valid and stall: an item
// moves at a rising edge with valid high and stall low.
// Configuration registers are written through the cfg_ port, which is always
// ready; it is to be written only while the block is idle.
// Every table walk reads one entry per cycle from the entry memory. From the
// accepting edge to the result being offered, an advertisement takes a
// lookup walk, the write state, a sweep walk and the hand-over state; a send,
// or a new sink on a full table, takes both walks and the hand-over; a stale
// advertisement or a relay that needs the table takes a lookup walk and the
// hand-over; relays decided by address alone and unused modes take only the
// hand-over.
// The block works on one item at a time and holds in_stall high meanwhile.
// The result sits in an output register; while the receiver stalls, the block
// still accepts and works on the next item and then waits to hand it over.
// Synchronous reset clears all valid bits and control state and restores the
// register defaults; the entry memory itself needs no clearing.
module sink_tree_routing_table_top
  import stt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DefTableEntries
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_sink_id,
  input  logic [15:0] in_neighbor_id,
  input  logic [7:0]  in_hop_count,
  input  logic [31:0] in_sink_time,
  input  logic [15:0] in_addressed_hop,
  input  logic [7:0]  in_ttl_in,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [15:0] out_next_hop,
  output logic [7:0]  out_ttl_out,
  output logic        out_rebroadcast,
  output logic [4:0]  out_expired_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LastCnt = CW'(TABLE_ENTRIES);

  // Configuration registers.
  logic [15:0] own_id_r;
  logic [31:0] expiry_r;
  logic [7:0]  max_hops_r;
  logic [7:0]  msg_ttl_r;

  // Latched item.
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] sink_r, sink_nxt;
  logic [15:0] nbr_r, nbr_nxt;
  logic [7:0]  hops_r, hops_nxt;
  logic [31:0] stime_r, stime_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [31:0] now_r, now_nxt;

  state_t state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pv_r, pv_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic          swept_r, swept_nxt;

  logic          fnd_r, fnd_nxt;
  logic [IW-1:0] fidx_r, fidx_nxt;
  logic [15:0]   fnh_r, fnh_nxt;
  logic [7:0]    fhops_r, fhops_nxt;
  logic [31:0]   fcreated_r, fcreated_nxt;
  logic          free_r, free_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic [IW-1:0] slot_r, slot_nxt;

  logic [3:0]  res_status_r, res_status_nxt;
  logic [15:0] res_nh_r, res_nh_nxt;
  logic [7:0]  res_ttl_r, res_ttl_nxt;
  logic        res_rb_r, res_rb_nxt;
  logic [4:0]  expd_r, expd_nxt;

  logic        out_valid_r;
  logic [3:0]  out_status_r;
  logic [15:0] out_nh_r;
  logic [7:0]  out_ttl_r;
  logic        out_rb_r;
  logic [4:0]  out_expd_r;

  logic        in_acc, scan_end, load_out;
  logic        ram_we;
  logic [IW-1:0] ram_raddr;
  entry_t      wr_entry, rd_entry;
  cmp_res_t    cmp;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign scan_end  = (cnt_r == LastCnt) && !pv_r;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign ram_we    = (state_r == ST_WRITE);
  assign ram_raddr = cnt_r[IW-1:0];
  assign wr_entry  = '{sink: sink_r, nhop: nbr_r, hops: hops_r, created: stime_r};

  stt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_r),
    .wdata(wr_entry),
    .raddr(ram_raddr),
    .rdata(rd_entry)
  );

  stt_cmp u_cmp (
    .entry   (rd_entry),
    .key_sink(sink_r),
    .now     (now_r),
    .expiry  (expiry_r),
    .res     (cmp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_ADV) begin
            state_nxt = ST_LOOK;
          end else if (in_mode == MODE_SEND) begin
            state_nxt = ST_SWEEP;
          end else if (in_mode == MODE_RELAY && in_addressed_hop == own_id_r &&
                       in_sink_id != own_id_r) begin
            state_nxt = ST_LOOK;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_LOOK: begin
        if (scan_end) begin
          if (mode_r == MODE_ADV) begin
            if (fnd_r && fhops_r <= hops_r && fcreated_r >= stime_r) begin
              state_nxt = ST_DONE;
            end else if (fnd_r || free_r) begin
              state_nxt = ST_WRITE;
            end else begin
              state_nxt = ST_SWEEP;
            end
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WRITE: state_nxt = ST_SWEEP;
      ST_SWEEP: begin
        if (scan_end) begin
          state_nxt = (mode_r == MODE_SEND) ? ST_LOOK : ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and scan control.
  always_comb begin
    mode_nxt       = mode_r;
    sink_nxt       = sink_r;
    nbr_nxt        = nbr_r;
    hops_nxt       = hops_r;
    stime_nxt      = stime_r;
    ttl_nxt        = ttl_r;
    now_nxt        = now_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = pidx_r;
    swept_nxt      = swept_r;
    fnd_nxt        = fnd_r;
    fidx_nxt       = fidx_r;
    fnh_nxt        = fnh_r;
    fhops_nxt      = fhops_r;
    fcreated_nxt   = fcreated_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_nh_nxt     = res_nh_r;
    res_ttl_nxt    = res_ttl_r;
    res_rb_nxt     = res_rb_r;
    expd_nxt       = expd_r;

    // Issue one memory read per cycle while a walk is running.
    if ((state_r == ST_LOOK || state_r == ST_SWEEP) && cnt_r != LastCnt) begin
      pv_nxt   = 1'b1;
      pidx_nxt = cnt_r[IW-1:0];
      cnt_nxt  = cnt_r + CW'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mode_nxt       = in_mode;
          sink_nxt       = in_sink_id;
          nbr_nxt        = in_neighbor_id;
          hops_nxt       = in_hop_count;
          stime_nxt      = in_sink_time;
          ttl_nxt        = in_ttl_in;
          now_nxt        = in_now;
          cnt_nxt        = '0;
          swept_nxt      = 1'b0;
          fnd_nxt        = 1'b0;
          free_nxt       = 1'b0;
          res_nh_nxt     = '0;
          res_ttl_nxt    = '0;
          res_rb_nxt     = 1'b0;
          expd_nxt       = '0;
          res_status_nxt = STAT_STALE;
          if (in_mode == MODE_RELAY) begin
            if (in_addressed_hop != own_id_r) begin
              res_status_nxt = STAT_NOT_FOR_ME;
            end else if (in_sink_id == own_id_r) begin
              res_status_nxt = STAT_DELIVERED;
            end
          end
        end
      end
      ST_LOOK: begin
        if (pv_r) begin
          if (valid_r[pidx_r] && cmp.match && !fnd_r) begin
            fnd_nxt      = 1'b1;
            fidx_nxt     = pidx_r;
            fnh_nxt      = rd_entry.nhop;
            fhops_nxt    = rd_entry.hops;
            fcreated_nxt = rd_entry.created;
          end
          if (!valid_r[pidx_r] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pidx_r;
          end
        end
        if (scan_end) begin
          cnt_nxt = '0;
          case (mode_r)
            MODE_ADV: begin
              if (fnd_r && fhops_r <= hops_r && fcreated_r >= stime_r) begin
                res_status_nxt = STAT_STALE;
              end else if (fnd_r) begin
                res_status_nxt = STAT_UPDATED;
                slot_nxt       = fidx_r;
                res_rb_nxt     = (hops_r < max_hops_r);
              end else if (free_r) begin
                res_status_nxt = STAT_INSERTED;
                slot_nxt       = free_idx_r;
                res_rb_nxt     = (hops_r < max_hops_r);
              end else begin
                res_status_nxt = STAT_FULL;
              end
            end
            MODE_SEND: begin
              if (fnd_r) begin
                res_status_nxt = STAT_ROUTED;
                res_nh_nxt     = fnh_r;
                res_ttl_nxt    = msg_ttl_r;
              end else begin
                res_status_nxt = STAT_NO_ROUTE;
              end
            end
            default: begin
              if (!fnd_r) begin
                res_status_nxt = STAT_NO_ROUTE;
              end else if (ttl_r != 8'd0) begin
                res_status_nxt = STAT_FORWARDED;
                res_nh_nxt     = fnh_r;
                res_ttl_nxt    = ttl_r;
              end else begin
                res_status_nxt = STAT_TTL_DEAD;
              end
            end
          endcase
        end
      end
      ST_WRITE: begin
        valid_nxt[slot_r] = 1'b1;
        cnt_nxt           = '0;
      end
      ST_SWEEP: begin
        if (pv_r && valid_r[pidx_r] && cmp.expired) begin
          valid_nxt[pidx_r] = 1'b0;
          if (expd_r != CountMax) begin
            expd_nxt = expd_r + 5'd1;
          end
        end
        if (scan_end) begin
          cnt_nxt   = '0;
          swept_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      swept_r     <= 1'b0;
      out_valid_r <= 1'b0;
      own_id_r    <= 16'd0;
      expiry_r    <= 32'd1000;
      max_hops_r  <= 8'd16;
      msg_ttl_r   <= 8'd16;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= pv_nxt;
      swept_r <= swept_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OWN_ID:   own_id_r   <= cfg_data[15:0];
          CFG_EXPIRY:   expiry_r   <= cfg_data;
          CFG_MAX_HOPS: max_hops_r <= cfg_data[7:0];
          CFG_MSG_TTL:  msg_ttl_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    sink_r       <= sink_nxt;
    nbr_r        <= nbr_nxt;
    hops_r       <= hops_nxt;
    stime_r      <= stime_nxt;
    ttl_r        <= ttl_nxt;
    now_r        <= now_nxt;
    pidx_r       <= pidx_nxt;
    fnd_r        <= fnd_nxt;
    fidx_r       <= fidx_nxt;
    fnh_r        <= fnh_nxt;
    fhops_r      <= fhops_nxt;
    fcreated_r   <= fcreated_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_nh_r     <= res_nh_nxt;
    res_ttl_r    <= res_ttl_nxt;
    res_rb_r     <= res_rb_nxt;
    expd_r       <= expd_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_nh_r     <= res_nh_r;
      out_ttl_r    <= res_ttl_r;
      out_rb_r     <= res_rb_r;
      out_expd_r   <= expd_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_next_hop      = out_nh_r;
  assign out_ttl_out       = out_ttl_r;
  assign out_rebroadcast   = out_rb_r;
  assign out_expired_count = out_expd_r;

`ifndef SYNTHESIS
  // A write into the table is always followed by the expiry sweep.
  a_write_then_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |=> state_r == ST_SWEEP)
    else $error("table write not followed by sweep");

  // Memory read data is only pending during a table walk.
  a_pending_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == ST_LOOK || state_r == ST_SWEEP))
    else $error("read pending outside a walk");

  // A new result only appears from the hand-over state.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside hand-over");

  // A send only looks up its route after the sweep.
  a_send_sweeps_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK && mode_r == MODE_SEND) |-> swept_r)
    else $error("send lookup before sweep");
`endif

endmodule
